/* rtl/core/prc_pkg.sv */
// ----------------------------------------------------------------------------
// prc_pkg: shared types and constants of the prime range count sieve
// Table depth, field widths, mode and status codes, payload structs and the
// sequencer states of the sieve unit.
// ----------------------------------------------------------------------------
package prc_pkg;

	localparam int MAX_NUMBERS = 131072;
	localparam int IDX_W = $clog2(MAX_NUMBERS);
	localparam int SQ_W = IDX_W + 1;
	localparam int LIM_W = 17;
	localparam int CNT_W = 14;

	localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(100000);
	localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_NUMBERS - 1);

	localparam logic MODE_BUILD = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_NOT_BUILT = 2'd1;
	localparam logic [1:0] STATUS_BAD_RANGE = 2'd2;

	typedef struct packed {
		logic             mode;
		logic [LIM_W-1:0] range_low;
		logic [LIM_W-1:0] range_high;
	} req_t;

	typedef struct packed {
		logic [CNT_W-1:0] prime_count;
		logic [1:0]       status;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT,
		S_SQ_RD,
		S_SQ_CHK,
		S_SQ_MARK,
		S_CNT,
		S_CDRAIN,
		S_QRD,
		S_QSUB,
		S_RESP
	} state_t;

endpackage

/* rtl/core/prime_range_count_sieve_unit.sv */
// ----------------------------------------------------------------------------
// prime_range_count_sieve_unit: sieve of Eratosthenes with prime count table
// Builds a prime map and a prefix count table on request, then answers
// the number of primes in an inclusive range from two table reads.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes the sieve limit; it is
//   always ready and must only be used while the unit is idle.
//   req channel carries one transaction per item: mode 0 builds the tables up
//   to the limit, mode 1 queries range_low..range_high. req_ready is high only
//   while the sequencer is idle, so one item is in flight at a time.
//   rsp channel returns one transaction per item from an output register; a
//   new request is taken while an earlier response still waits on rsp_ready.
// Sequence:
//   A query reads the prefix table through registered reads, subtracts,
//   then loads the output register. A query rejected at acceptance goes
//   straight to the output load. A build for limit L seeds the prime map
//   over 0..L, reads and checks each sieve candidate 2..floor(sqrt(L)),
//   clears the multiples of each prime candidate one write each, then
//   walks the map to fill the count table. Each item reaches the output
//   register before the next request is taken.
// Reset:
//   arst_n clears the sequencer, the built flag and the built limit, and
//   loads the limit register with 100000. The tables are not cleared; a query
//   before the first build answers status not_built.
// Stall:
//   When rsp_ready is low the finished response holds in the output register
//   and the sequencer waits in its response state until the slot frees.
// ----------------------------------------------------------------------------
module prime_range_count_sieve_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [prc_pkg::LIM_W-1:0]   cfg_data,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  prc_pkg::req_t               req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output prc_pkg::rsp_t               rsp
);

	localparam int IW = prc_pkg::IDX_W;
	localparam int SW = prc_pkg::SQ_W;
	localparam int CW = prc_pkg::CNT_W;
	localparam int LW = prc_pkg::LIM_W;

	// Storage: one bit per number, one count per number.
	logic          pm_mem [prc_pkg::MAX_NUMBERS];
	logic [CW-1:0] pf_mem [prc_pkg::MAX_NUMBERS];

	prc_pkg::state_t state_q, state_d;

	// Control and configuration registers.
	logic [LW-1:0] limit_q;
	logic          built_q;
	logic [IW-1:0] built_lim_q;
	logic          rsp_valid_q;
	prc_pkg::rsp_t rsp_q;

	// Datapath registers of the sequencer.
	logic [IW-1:0] lim_q;        // limit latched for the running build
	logic [IW-1:0] idx_q;        // walk counter, also the sieve candidate
	logic [SW-1:0] sq_q;         // square of the sieve candidate
	logic [SW-1:0] j_q;          // multiple being cleared
	logic [CW-1:0] cnt_q;        // running prime count
	logic [IW-1:0] lo_q;
	logic [IW-1:0] hi_q;
	logic [CW-1:0] res_count_q;
	logic [1:0]    res_status_q;

	// Count pipeline: read prime map, then accumulate and write the table.
	logic          vld_s1;
	logic [IW-1:0] addr_s1;

	// Registered memory read data.
	logic          pm_rd_q;
	logic [CW-1:0] pf_hi_q;
	logic [CW-1:0] pf_lo_q;

	// Combinational helpers.
	logic [SW-1:0] j_next;
	logic [SW-1:0] sq_next;
	logic [CW-1:0] cnt_next;
	logic [IW-1:0] lo_m1;
	logic [IW-1:0] lim_sat;
	logic          rsp_free;
	logic          req_take;
	logic          pm_we;
	logic [IW-1:0] pm_waddr;
	logic          pm_wdata;

	assign j_next   = j_q + {1'b0, idx_q};
	// (i+1)^2 = i^2 + 2i + 1
	assign sq_next  = sq_q + {idx_q, 1'b1};
	assign cnt_next = cnt_q + CW'(pm_rd_q);
	assign lo_m1    = lo_q - IW'(1);
	assign lim_sat  = (limit_q > LW'(prc_pkg::IDX_MAX)) ? prc_pkg::IDX_MAX : IW'(limit_q);
	assign rsp_free = !rsp_valid_q || rsp_ready;
	assign req_take = req_valid && req_ready;

	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ------------------------------------------------------------------
	// Next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			prc_pkg::S_IDLE: begin
				if (req_valid) begin
					if (req.mode == prc_pkg::MODE_BUILD) begin
						state_d = prc_pkg::S_INIT;
					end else if (!built_q || req.range_low > req.range_high
							|| req.range_high > LW'(built_lim_q)) begin
						state_d = prc_pkg::S_RESP;
					end else begin
						state_d = prc_pkg::S_QRD;
					end
				end
			end
			prc_pkg::S_INIT: begin
				if (idx_q == lim_q) state_d = prc_pkg::S_SQ_RD;
			end
			prc_pkg::S_SQ_RD: begin
				// Stop sieving once the candidate square passes the limit.
				if (sq_q > {1'b0, lim_q}) state_d = prc_pkg::S_CNT;
				else state_d = prc_pkg::S_SQ_CHK;
			end
			prc_pkg::S_SQ_CHK: begin
				if (pm_rd_q) state_d = prc_pkg::S_SQ_MARK;
				else state_d = prc_pkg::S_SQ_RD;
			end
			prc_pkg::S_SQ_MARK: begin
				if (j_next > {1'b0, lim_q}) state_d = prc_pkg::S_SQ_RD;
			end
			prc_pkg::S_CNT: begin
				if (idx_q == lim_q) state_d = prc_pkg::S_CDRAIN;
			end
			prc_pkg::S_CDRAIN: state_d = prc_pkg::S_RESP;
			prc_pkg::S_QRD:    state_d = prc_pkg::S_QSUB;
			prc_pkg::S_QSUB:   state_d = prc_pkg::S_RESP;
			prc_pkg::S_RESP: begin
				if (rsp_free) state_d = prc_pkg::S_IDLE;
			end
			default: state_d = prc_pkg::S_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Outputs of the sequencer: handshake and prime map write port
	// ------------------------------------------------------------------
	always_comb begin
		req_ready = 1'b0;
		pm_we     = 1'b0;
		pm_waddr  = idx_q;
		pm_wdata  = 1'b0;
		case (state_q)
			prc_pkg::S_IDLE: req_ready = 1'b1;
			prc_pkg::S_INIT: begin
				// Seed: 0 and 1 are not prime, everything else may be.
				pm_we    = 1'b1;
				pm_waddr = idx_q;
				pm_wdata = (idx_q >= IW'(2));
			end
			prc_pkg::S_SQ_MARK: begin
				pm_we    = 1'b1;
				pm_waddr = j_q[IW-1:0];
				pm_wdata = 1'b0;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Memories: one write and registered reads per cycle
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (pm_we) pm_mem[pm_waddr] <= pm_wdata;
		pm_rd_q <= pm_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (vld_s1) pf_mem[addr_s1] <= cnt_next;
		pf_hi_q <= pf_mem[hi_q];
		// Entry below zero wraps; its value is dropped when range_low is 0.
		pf_lo_q <= pf_mem[lo_m1];
	end

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= prc_pkg::S_IDLE;
			limit_q     <= prc_pkg::LIMIT_RESET;
			built_q     <= 1'b0;
			built_lim_q <= '0;
			rsp_valid_q <= 1'b0;
			vld_s1      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) limit_q <= cfg_data;
			vld_s1 <= (state_q == prc_pkg::S_CNT);
			if (state_q == prc_pkg::S_CDRAIN) begin
				built_q     <= 1'b1;
				built_lim_q <= lim_q;
			end
			// Hold the response until taken; reload as the slot frees.
			if (state_q == prc_pkg::S_RESP && rsp_free) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		addr_s1 <= idx_q;
		if (vld_s1) cnt_q <= cnt_next;
		case (state_q)
			prc_pkg::S_IDLE: begin
				lim_q        <= lim_sat;
				idx_q        <= '0;
				lo_q         <= IW'(req.range_low);
				hi_q         <= IW'(req.range_high);
				res_count_q  <= '0;
				if (!built_q) begin
					res_status_q <= prc_pkg::STATUS_NOT_BUILT;
				end else begin
					res_status_q <= prc_pkg::STATUS_BAD_RANGE;
				end
			end
			prc_pkg::S_INIT: begin
				if (idx_q == lim_q) begin
					idx_q <= IW'(2);
					sq_q  <= SW'(4);
				end else begin
					idx_q <= idx_q + IW'(1);
				end
			end
			prc_pkg::S_SQ_RD: begin
				if (sq_q > {1'b0, lim_q}) begin
					idx_q <= '0;
					cnt_q <= '0;
				end
			end
			prc_pkg::S_SQ_CHK: begin
				if (pm_rd_q) begin
					j_q <= sq_q;
				end else begin
					idx_q <= idx_q + IW'(1);
					sq_q  <= sq_next;
				end
			end
			prc_pkg::S_SQ_MARK: begin
				j_q <= j_next;
				if (j_next > {1'b0, lim_q}) begin
					idx_q <= idx_q + IW'(1);
					sq_q  <= sq_next;
				end
			end
			prc_pkg::S_CNT: begin
				if (idx_q != lim_q) idx_q <= idx_q + IW'(1);
			end
			prc_pkg::S_CDRAIN: begin
				res_count_q  <= cnt_next;
				res_status_q <= prc_pkg::STATUS_OK;
			end
			prc_pkg::S_QSUB: begin
				res_count_q  <= pf_hi_q - ((lo_q == '0) ? CW'(0) : pf_lo_q);
				res_status_q <= prc_pkg::STATUS_OK;
			end
			prc_pkg::S_RESP: begin
				if (rsp_free) begin
					rsp_q.prime_count <= res_count_q;
					rsp_q.status      <= res_status_q;
				end
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_mark_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == prc_pkg::S_SQ_MARK |-> j_q <= {1'b0, lim_q})
		else $error("sieve clears a multiple past the limit");

	a_chk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == prc_pkg::S_SQ_CHK |-> sq_q <= {1'b0, lim_q})
		else $error("sieve candidate checked with square past the limit");

	a_pipe_in_count: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == prc_pkg::S_CNT || state_q == prc_pkg::S_CDRAIN))
		else $error("count pipeline active outside the count walk");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |=> !req_ready)
		else $error("request accepted while another transaction is in flight");

	a_built_at_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(built_q) |-> state_q == prc_pkg::S_RESP)
		else $error("table marked built outside the end of a build");

endmodule

/* dv/prc_checker.sv */
// ----------------------------------------------------------------------------
// prc_count_checker: response checker for the prime range count sieve unit
// Watches the limit, request and response channels, keeps its own sieve
// and prime count table, and compares every response with the oldest
// expected one. Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module prc_count_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [prc_pkg::LIM_W-1:0] cfg_data,
	input  logic                      req_valid,
	input  logic                      req_ready,
	input  prc_pkg::req_t             req,
	input  logic                      rsp_valid,
	input  logic                      rsp_ready,
	input  prc_pkg::rsp_t             rsp,
	output int                        errors,
	output int                        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	bit                        is_prime_flag [prc_pkg::MAX_NUMBERS];
	logic [prc_pkg::CNT_W-1:0] primes_upto [prc_pkg::MAX_NUMBERS];
	logic [prc_pkg::LIM_W-1:0] limit_reg;
	bit                        table_ready;
	int                        table_top;
	prc_pkg::rsp_t             count_q [$];

	// Work out the response to one request and update the table state.
	function automatic prc_pkg::rsp_t predict_count(input prc_pkg::req_t item);
		prc_pkg::rsp_t res;
		int   lim;
		int   i;
		int   j;
		int   total;
		int   lower;
		res = '0;
		res.status = prc_pkg::STATUS_OK;
		if (item.mode == prc_pkg::MODE_BUILD) begin
			lim = int'(limit_reg);
			for (i = 0; i <= lim; i++)
				is_prime_flag[i] = (i >= 2);
			for (i = 2; i * i <= lim; i++) begin
				if (is_prime_flag[i]) begin
					for (j = i * i; j <= lim; j += i)
						is_prime_flag[j] = 1'b0;
				end
			end
			total = 0;
			for (i = 0; i <= lim; i++) begin
				total += int'(is_prime_flag[i]);
				primes_upto[i] = prc_pkg::CNT_W'(total);
			end
			table_top = lim;
			table_ready = 1'b1;
			res.prime_count = prc_pkg::CNT_W'(total);
		end else if (!table_ready) begin
			res.status = prc_pkg::STATUS_NOT_BUILT;
		end else if (item.range_low > item.range_high
				|| int'(item.range_high) > table_top) begin
			res.status = prc_pkg::STATUS_BAD_RANGE;
		end else begin
			lower = (item.range_low == 0) ? 0 : int'(primes_upto[item.range_low - 1]);
			res.prime_count = prc_pkg::CNT_W'(int'(primes_upto[item.range_high]) - lower);
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		prc_pkg::rsp_t want;
		if (!arst_n) begin
			limit_reg = prc_pkg::LIMIT_RESET;
			table_ready = 1'b0;
			table_top = 0;
			count_q.delete();
			pending <= 0;
		end else begin
			// Retire first so a response never pairs with a request of the same edge.
			if (rsp_valid && rsp_ready) begin
				if (count_q.size() == 0) begin
					errors++;
					$display("%t unexpected response: expected none, actual count %0d status %0d",
						$time, rsp.prime_count, rsp.status);
				end else begin
					want = count_q.pop_front();
					if (rsp.prime_count !== want.prime_count) begin
						errors++;
						$display("%t prime_count mismatch: expected %0d, actual %0d",
							$time, want.prime_count, rsp.prime_count);
					end
					if (rsp.status !== want.status) begin
						errors++;
						$display("%t status mismatch: expected %0d, actual %0d",
							$time, want.status, rsp.status);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				limit_reg = cfg_data;
			if (req_valid && req_ready)
				count_q.push_back(predict_count(req));
			pending <= count_q.size();
		end
	end

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench top of the prime range count sieve unit
// Drives limit writes, builds and range queries with random stalls on both
// sides, and reports the verdict from the failure count of the checker.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int   TOP_VALUE  = prc_pkg::MAX_NUMBERS - 1;
	localparam int   PHASE_ITEMS = 667;
	localparam int   REBUILD_EVERY = 80;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [prc_pkg::LIM_W-1:0] cfg_data;
	logic                      req_valid;
	logic                      req_ready;
	prc_pkg::req_t             req;
	logic                      rsp_valid;
	logic                      rsp_ready;
	prc_pkg::rsp_t             rsp;
	int                        errors;
	int                        pending;

	// Stall rates in percent: sender gaps before a transaction, receiver
	// backpressure per cycle.
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int tx_plan [3] = '{27, 84, 0};
	int rx_plan [3] = '{84, 27, 0};

	// Stimulus-side view of the limit, used only to aim queries at the table.
	int limit_top = 100000;
	int built_top = -1;
	int n_builds = 0;
	int n_queries = 0;
	int n_writes = 0;

	prime_range_count_sieve_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	prc_count_checker u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.errors    (errors),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Receiver backpressure: drop ready at random at the configured rate.
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// Present one request transaction and hold it until it is accepted.
	// Valid stays high on return so back-to-back transactions need no
	// second assignment in the same step.
	task automatic send_item(input prc_pkg::req_t item);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		if (item.mode == prc_pkg::MODE_BUILD) begin
			n_builds++;
			built_top = limit_top;
		end else begin
			n_queries++;
		end
	endtask

	// Build with noise in the ignored range fields.
	task automatic send_build();
		prc_pkg::req_t item;
		item.mode = prc_pkg::MODE_BUILD;
		item.range_low = prc_pkg::LIM_W'($urandom);
		item.range_high = prc_pkg::LIM_W'($urandom);
		send_item(item);
	endtask

	task automatic send_query(input int lo, input int hi);
		prc_pkg::req_t item;
		item.mode = prc_pkg::MODE_QUERY;
		item.range_low = prc_pkg::LIM_W'(lo);
		item.range_high = prc_pkg::LIM_W'(hi);
		send_item(item);
	endtask

	// Hold the sender until every response is back, then write the limit.
	// Every request answers, so an empty queue means the unit is idle.
	task automatic program_limit(input int value);
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= prc_pkg::LIM_W'(value);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		limit_top = value;
		n_writes++;
	endtask

	initial begin
		int ph;
		int n;
		int r;
		int lo;
		int hi;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		req_valid <= 1'b0;
		req <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = tx_plan[0];
		rx_idle_pct <= rx_plan[0];

		// Queries before the first build: all answer not built, even an
		// inverted or out-of-table range.
		send_query(0, 0);
		send_query(TOP_VALUE, 0);
		send_query(0, TOP_VALUE);

		// Limit of zero: the build still runs and finds nothing.
		program_limit(0);
		send_build();
		send_query(0, 0);
		send_query(0, 1);

		// Limit of one, then two: the smallest table holding a prime.
		program_limit(1);
		send_build();
		send_query(1, 1);
		program_limit(2);
		send_build();
		send_query(2, 2);
		send_query(0, 2);
		send_query(3, 2);

		// Largest limit: full table, ranges touching both ends.
		program_limit(TOP_VALUE);
		send_build();
		send_query(0, TOP_VALUE);
		send_query(TOP_VALUE, TOP_VALUE);
		send_query(TOP_VALUE - 1, TOP_VALUE);
		send_query(1, TOP_VALUE);
		send_query(TOP_VALUE, 0);
		send_query(65536, 65536);

		// Shrink the table: a high end past the last build's limit is
		// rejected even though a larger table was built before.
		program_limit(30);
		send_build();
		send_query(0, TOP_VALUE);
		send_query(0, 30);
		send_query(0, 31);

		// Random part, three stall phases. Each phase opens with a fresh
		// limit and build so queries land inside the table.
		for (ph = 0; ph < 3; ph++) begin
			tx_idle_pct = tx_plan[ph];
			rx_idle_pct <= rx_plan[ph];
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n % REBUILD_EVERY == 0) begin
					// Mostly small tables keep builds short; a few tiny and a
					// few mid-sized ones.
					r = $urandom_range(0, 99);
					if (r < 10)
						program_limit($urandom_range(0, 3));
					else if (r < 20)
						program_limit($urandom_range(2000, 5000));
					else
						program_limit($urandom_range(4, 1000));
					send_build();
				end else if ($urandom_range(0, 99) == 0) begin
					// Rebuild with the same limit in the middle of a stream.
					send_build();
				end else begin
					r = $urandom_range(0, 99);
					hi = $urandom_range(0, built_top);
					lo = $urandom_range(0, hi);
					if (r < 10) begin
						// Noise across the whole field width.
						lo = $urandom_range(0, TOP_VALUE);
						hi = $urandom_range(0, TOP_VALUE);
					end else if (r < 18) begin
						// Inverted range.
						if (hi == TOP_VALUE)
							hi--;
						lo = (r < 13) ? hi + 1 : $urandom_range(hi + 1, TOP_VALUE);
					end else if (r < 26) begin
						// High end just past or far past the table.
						if (built_top < TOP_VALUE)
							hi = (r < 22) ? built_top + 1 :
								$urandom_range(built_top + 1, TOP_VALUE);
					end else if (r < 34) begin
						lo = 0;
					end else if (r < 42) begin
						hi = built_top;
					end else if (r < 48) begin
						lo = hi;
					end
					send_query(lo, hi);
				end
			end
		end

		// Drain: wait for every outstanding response, then a short tail to
		// catch anything spurious.
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		$display("Covered %0d builds and %0d range queries over %0d limit writes,",
			n_builds, n_queries, n_writes);
		$display("with sender and receiver stalls swapped between phases and a stall-free phase.");
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog: the full-table build dominates the run; allow several times
	// the whole run.
	initial begin
		#40_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
